[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/b32ad_pkg.sv]
// Types, constants and helper functions for the bech32 address decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package b32ad_pkg;

	localparam int MAX_DATA_CHARS = 127;
	localparam int DCNT_W         = $clog2(MAX_DATA_CHARS + 1);
	localparam int HOLD_DEPTH     = 6;
	localparam int MIN_DATA       = 7;
	localparam int PFX_DEPTH      = 4;
	localparam int OQ_DEPTH       = 4;
	localparam int OQ_AW          = $clog2(OQ_DEPTH);

	localparam logic [29:0] GEN0          = 30'h3b6a57b2;
	localparam logic [29:0] GEN1          = 30'h26508e6d;
	localparam logic [29:0] GEN2          = 30'h1ea119fa;
	localparam logic [29:0] GEN3          = 30'h3d4233dd;
	localparam logic [29:0] GEN4          = 30'h2a1462b3;
	localparam logic [29:0] BECH32M_CONST = 30'h2bc830a3;
	localparam logic [29:0] CHK_INIT      = 30'h1;

	localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

	localparam logic [7:0] CH_SEP = 8'h31;

	// prefix bytes, first character in the low byte
	localparam logic [31:0] PFX_MAIN = {8'h00, 8'h6e, 8'h69, 8'h64};
	localparam logic [31:0] PFX_TEST = {8'h6e, 8'h69, 8'h64, 8'h74};
	localparam logic [31:0] PFX_REG  = {8'h6e, 8'h69, 8'h64, 8'h72};

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_NOT_BECH32 = 4'd1;
	localparam logic [3:0] ST_CHARSET    = 4'd2;
	localparam logic [3:0] ST_SHORT      = 4'd3;
	localparam logic [3:0] ST_CHECKSUM   = 4'd4;
	localparam logic [3:0] ST_VERSION    = 4'd5;
	localparam logic [3:0] ST_PADDING    = 4'd6;
	localparam logic [3:0] ST_V0LEN      = 4'd7;
	localparam logic [3:0] ST_V1LEN      = 4'd8;
	localparam logic [3:0] ST_VARIANT    = 4'd9;

	localparam logic [1:0] NET_MAIN = 2'd0;
	localparam logic [1:0] NET_TEST = 2'd1;
	localparam logic [1:0] NET_REG  = 2'd2;
	localparam logic [1:0] NET_NONE = 2'd3;

	localparam logic [1:0] AT_KEYHASH    = 2'd0;
	localparam logic [1:0] AT_SCRIPTHASH = 2'd1;
	localparam logic [1:0] AT_TAPROOT    = 2'd2;

	typedef struct packed {
		logic       is_summary;
		logic [7:0] prog_byte;
		logic [3:0] status;
		logic [1:0] addr_type;
		logic [1:0] network_id;
		logic [5:0] prog_length;
	} res_t;

	typedef struct packed {
		logic push_a;
		logic push_b;
		res_t res_a;
		res_t res_b;
	} push_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

	function automatic logic [29:0] pm_step(input logic [29:0] chk, input logic [4:0] v);
		logic [4:0]  top;
		logic [29:0] r;
		top = chk[29:25];
		r   = {chk[24:0], v};
		if (top[0]) r = r ^ GEN0;
		if (top[1]) r = r ^ GEN1;
		if (top[2]) r = r ^ GEN2;
		if (top[3]) r = r ^ GEN3;
		if (top[4]) r = r ^ GEN4;
		return r;
	endfunction

	function automatic logic [29:0] prefix_seed(input logic [31:0] pfx, input int n);
		logic [29:0] chk;
		chk = CHK_INIT;
		for (int i = 0; i < 4; i++)
			if (i < n) chk = pm_step(chk, {2'b00, pfx[8*i+5 +: 3]});
		chk = pm_step(chk, 5'd0);
		for (int i = 0; i < 4; i++)
			if (i < n) chk = pm_step(chk, pfx[8*i +: 5]);
		return chk;
	endfunction

	localparam logic [29:0] SEED_MAIN = prefix_seed(PFX_MAIN, 3);
	localparam logic [29:0] SEED_TEST = prefix_seed(PFX_TEST, 4);
	localparam logic [29:0] SEED_REG  = prefix_seed(PFX_REG, 4);

	// bit 5 set: not in the alphabet
	function automatic logic [5:0] charset_value(input logic [7:0] c);
		logic [5:0] v;
		logic       hit;
		v   = '0;
		hit = 1'b0;
		for (int i = 0; i < 32; i++)
			if (ALPHABET[8*(31-i) +: 8] == c) begin
				v   = v | 6'(i);
				hit = 1'b1;
			end
		return hit ? v : 6'd32;
	endfunction

	function automatic logic [1:0] match_net(input logic [3:0][7:0] pbuf,
		input logic [2:0] pcnt, input logic povf);
		logic [1:0] net;
		net = NET_NONE;
		if (!povf) begin
			if (pcnt == 3'd3 && pbuf[2:0] == PFX_MAIN[23:0]) net = NET_MAIN;
			else if (pcnt == 3'd4 && pbuf == PFX_TEST) net = NET_TEST;
			else if (pcnt == 3'd4 && pbuf == PFX_REG) net = NET_REG;
		end
		return net;
	endfunction

endpackage
`default_nettype wire

[sv/b32ad_engine.sv]
// Input register and single-pass decode step: prefix match, polymod,
// holdback line, 5-to-8 regrouping and summary. Depends on b32ad_pkg.
`default_nettype none
module b32ad_engine
	import b32ad_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_in,
	input  wire logic       end_of_text,
	input  wire logic       room,
	output push_t           push
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eot_s1;
	logic       fire;

	logic [3:0][7:0]            pbuf_q, n_pbuf;
	logic [2:0]                 pcnt_q, n_pcnt;
	logic                       povf_q, n_povf;
	logic                       psep_q, n_psep;
	logic [29:0]                chk_q, n_chk;
	logic [HOLD_DEPTH-1:0][4:0] hold_q, n_hold;
	logic [DCNT_W-1:0]          dcnt_q, n_dcnt;
	logic [4:0]                 wver_q, n_wver;
	logic [11:0]                acc_q, n_acc;
	logic [3:0]                 bcnt_q, n_bcnt;
	logic [5:0]                 bytes_q, n_bytes;
	logic                       cfault_q, n_cfault;
	logic                       xsep_q, n_xsep;

	logic [7:0]  c;
	logic [5:0]  v6;
	logic [1:0]  net_cur, net_nxt;
	logic [11:0] acc_sh;
	logic [3:0]  bsum;
	logic        byte_hit;
	logic [7:0]  byte_val;
	logic        is32, is32m;
	logic [7:0]  pad_mask;
	logic [3:0]  st;
	logic [1:0]  ty;
	res_t        res_byte, res_sum;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
			eot_s1  <= end_of_text;
		end
	end

	always_comb begin
		c        = fold(char_s1);
		v6       = charset_value(c);
		net_cur  = match_net(pbuf_q, pcnt_q, povf_q);
		n_pbuf   = pbuf_q;
		n_pcnt   = pcnt_q;
		n_povf   = povf_q;
		n_psep   = psep_q;
		n_chk    = chk_q;
		n_hold   = hold_q;
		n_dcnt   = dcnt_q;
		n_wver   = wver_q;
		n_acc    = acc_q;
		n_bcnt   = bcnt_q;
		n_bytes  = bytes_q;
		n_cfault = cfault_q;
		n_xsep   = xsep_q;
		acc_sh   = {acc_q[6:0], hold_q[0]};
		bsum     = bcnt_q + 4'd5;
		byte_hit = 1'b0;
		byte_val = '0;
		if (!psep_q) begin
			if (c == CH_SEP) begin
				n_psep = 1'b1;
				case (net_cur)
					NET_MAIN: n_chk = SEED_MAIN;
					NET_TEST: n_chk = SEED_TEST;
					NET_REG:  n_chk = SEED_REG;
					default:  n_chk = CHK_INIT;
				endcase
			end else if (pcnt_q < 3'(PFX_DEPTH)) begin
				n_pbuf[pcnt_q[1:0]] = c;
				n_pcnt              = pcnt_q + 3'd1;
			end else begin
				n_povf = 1'b1;
			end
		end else if (c == CH_SEP) begin
			n_xsep = 1'b1;
		end else if (v6[5]) begin
			n_cfault = 1'b1;
		end else begin
			n_chk  = pm_step(chk_q, v6[4:0]);
			n_hold = {v6[4:0], hold_q[HOLD_DEPTH-1:1]};
			if (dcnt_q < DCNT_W'(MAX_DATA_CHARS))
				n_dcnt = dcnt_q + DCNT_W'(1);
			if (dcnt_q == DCNT_W'(HOLD_DEPTH)) begin
				n_wver = hold_q[0];
			end else if (dcnt_q > DCNT_W'(HOLD_DEPTH)) begin
				n_acc = acc_sh;
				if (bsum >= 4'd8) begin
					bsum     = bsum - 4'd8;
					byte_hit = 1'b1;
					byte_val = 8'(acc_sh >> bsum);
					if (bytes_q != 6'h3f)
						n_bytes = bytes_q + 6'd1;
				end
				n_bcnt = bsum;
			end
		end

		net_nxt  = match_net(n_pbuf, n_pcnt, n_povf);
		is32     = n_chk == CHK_INIT;
		is32m    = n_chk == BECH32M_CONST;
		pad_mask = (8'd1 << n_bcnt[2:0]) - 8'd1;
		st       = ST_OK;
		ty       = AT_KEYHASH;
		if (!n_psep || n_xsep || net_nxt == NET_NONE)
			st = ST_NOT_BECH32;
		else if (n_cfault)
			st = ST_CHARSET;
		else if (n_dcnt < DCNT_W'(MIN_DATA))
			st = ST_SHORT;
		else if (!is32 && !is32m)
			st = ST_CHECKSUM;
		else if (n_wver > 5'd16)
			st = ST_VERSION;
		else if (n_bcnt >= 4'd5 || (n_acc[7:0] & pad_mask) != 8'd0)
			st = ST_PADDING;
		else if (n_wver == 5'd0 && is32) begin
			if (n_bytes == 6'd20) ty = AT_KEYHASH;
			else if (n_bytes == 6'd32) ty = AT_SCRIPTHASH;
			else st = ST_V0LEN;
		end else if (n_wver == 5'd1 && is32m) begin
			if (n_bytes == 6'd32) ty = AT_TAPROOT;
			else st = ST_V1LEN;
		end else
			st = ST_VARIANT;
		if (st != ST_OK)
			ty = AT_KEYHASH;

		res_byte.is_summary  = 1'b0;
		res_byte.prog_byte   = byte_val;
		res_byte.status      = ST_OK;
		res_byte.addr_type   = AT_KEYHASH;
		res_byte.network_id  = (net_cur == NET_NONE) ? NET_MAIN : net_cur;
		res_byte.prog_length = n_bytes;

		res_sum.is_summary   = 1'b1;
		res_sum.prog_byte    = 8'd0;
		res_sum.status       = st;
		res_sum.addr_type    = ty;
		res_sum.network_id   = (net_nxt == NET_NONE) ? NET_MAIN : net_nxt;
		res_sum.prog_length  = n_bytes;

		push.push_a = fire && (byte_hit || eot_s1);
		push.push_b = fire && byte_hit && eot_s1;
		push.res_a  = byte_hit ? res_byte : res_sum;
		push.res_b  = res_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbuf_q   <= '0;
			pcnt_q   <= '0;
			povf_q   <= 1'b0;
			psep_q   <= 1'b0;
			chk_q    <= CHK_INIT;
			hold_q   <= '0;
			dcnt_q   <= '0;
			wver_q   <= '0;
			acc_q    <= '0;
			bcnt_q   <= '0;
			bytes_q  <= '0;
			cfault_q <= 1'b0;
			xsep_q   <= 1'b0;
		end else if (fire) begin
			if (eot_s1) begin
				pbuf_q   <= '0;
				pcnt_q   <= '0;
				povf_q   <= 1'b0;
				psep_q   <= 1'b0;
				chk_q    <= CHK_INIT;
				hold_q   <= '0;
				dcnt_q   <= '0;
				wver_q   <= '0;
				acc_q    <= '0;
				bcnt_q   <= '0;
				bytes_q  <= '0;
				cfault_q <= 1'b0;
				xsep_q   <= 1'b0;
			end else begin
				pbuf_q   <= n_pbuf;
				pcnt_q   <= n_pcnt;
				povf_q   <= n_povf;
				psep_q   <= n_psep;
				chk_q    <= n_chk;
				hold_q   <= n_hold;
				dcnt_q   <= n_dcnt;
				wver_q   <= n_wver;
				acc_q    <= n_acc;
				bcnt_q   <= n_bcnt;
				bytes_q  <= n_bytes;
				cfault_q <= n_cfault;
				xsep_q   <= n_xsep;
			end
		end
	end

endmodule
`default_nettype wire

[sv/b32ad_outq.sv]
// Result queue: takes up to two result words per cycle, gives one while out_ready is high.
// Depends on b32ad_pkg.
`default_nettype none
module b32ad_outq
	import b32ad_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output res_t       head
);

	res_t             mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_q, rd_q;
	logic [OQ_AW:0]   cnt_q;
	logic [OQ_AW:0]   npush;
	logic             pop;

	assign npush     = (OQ_AW+1)'(push.push_a) + (OQ_AW+1)'(push.push_b);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign room      = cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + npush[OQ_AW-1:0];
			rd_q  <= rd_q + OQ_AW'(pop);
			cnt_q <= cnt_q + npush - (OQ_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.push_a)
			mem_q[wr_q] <= push.res_a;
		if (push.push_b)
			mem_q[wr_q + OQ_AW'(1)] <= push.res_b;
	end

endmodule
`default_nettype wire

[sv/bech32_address_decoder_core.sv]
// Path: a character word passes the input register; its result words pass the result queue.
// Throughput: one character per cycle while the result queue has room; a final character that
// also ends a byte gives two result words, drained one per ready cycle via a four-word queue.
// Reset: arst_n clears the decode state, the input register and the queue at once.
// Top level of the bech32 address decoder; depends on b32ad_pkg,
// b32ad_engine and b32ad_outq.
`default_nettype none
module bech32_address_decoder_core
	import b32ad_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_in,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            is_summary,
	output logic [7:0]      prog_byte,
	output logic [3:0]      status,
	output logic [1:0]      addr_type,
	output logic [1:0]      network_id,
	output logic [5:0]      prog_length,
	output logic            last_result
);

	push_t push;
	logic  room;
	res_t  head;

	b32ad_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_in     (char_in),
		.end_of_text (end_of_text),
		.room        (room),
		.push        (push)
	);

	b32ad_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign is_summary  = head.is_summary;
	assign prog_byte   = head.prog_byte;
	assign status      = head.status;
	assign addr_type   = head.addr_type;
	assign network_id  = head.network_id;
	assign prog_length = head.prog_length;
	assign last_result = head.is_summary;

endmodule
`default_nettype wire

[sv/b32ad_checker.sv]
// Port-level checker for the bech32 address decoder, bound to the top level.
// Depends on b32ad_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module b32ad_checker
	import b32ad_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       is_summary,
	input wire logic [7:0] prog_byte,
	input wire logic [3:0] status,
	input wire logic [1:0] addr_type,
	input wire logic [1:0] network_id,
	input wire logic [5:0] prog_length,
	input wire logic       last_result
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(prog_byte) && $stable(status) && $stable(is_summary))
	`ASSERT_IMPLY(a_last_is_summary, clk, arst_n, out_valid, last_result == is_summary)
	`ASSERT_IMPLY(a_byte_word_clean, clk, arst_n, out_valid && !is_summary, status == ST_OK && addr_type == AT_KEYHASH && network_id != NET_NONE)
	`ASSERT_IMPLY(a_fail_no_type, clk, arst_n, out_valid && is_summary && status != ST_OK, addr_type == AT_KEYHASH && prog_byte == 8'd0)
	`ASSERT_IMPLY(a_ok_length, clk, arst_n, out_valid && is_summary && status == ST_OK, prog_length == 6'd20 || prog_length == 6'd32)

endmodule

bind bech32_address_decoder_core b32ad_checker u_b32ad_checker (.*);
`default_nettype wire

[tb/bech32_address_decoder_core_test.sv]
// Self-checking bench for bech32_address_decoder_core: streams address text one character
// at a time, predicts every byte and summary word, and compares them in order.
// Depends on b32ad_pkg for status, network and type codes and the checksum constants.
`default_nettype none
module bech32_address_decoder_core_test;
	import b32ad_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_CHARS = 1500;
	localparam int CALM_AFTER   = 1200;
	localparam int N_DIRECTED   = 26;

	typedef struct packed {
		logic       summary;
		logic [7:0] pbyte;
		logic [3:0] st;
		logic [1:0] atype;
		logic [1:0] net;
		logic [5:0] plen;
		logic       last;
	} addr_word_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
		logic       typed;
		logic [3:0] st;
		logic [1:0] net;
	} char_row_t;

	typedef enum int {CASE_LOWER, CASE_UPPER, CASE_MIXED} case_style_t;
	typedef enum int {MUT_SWAP_SYMBOL, MUT_INSERT_BYTE, MUT_INSERT_SEP, MUT_DROP_CHAR,
		MUT_TRUNCATE, MUT_OVERWRITE} mutation_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_in;
	logic       end_of_text;
	logic       out_valid;
	logic       out_ready;
	logic       is_summary;
	logic [7:0] prog_byte;
	logic [3:0] status;
	logic [1:0] addr_type;
	logic [1:0] network_id;
	logic [5:0] prog_length;
	logic       last_result;

	bech32_address_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_in(char_in),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_summary(is_summary),
		.prog_byte(prog_byte),
		.status(status),
		.addr_type(addr_type),
		.network_id(network_id),
		.prog_length(prog_length),
		.last_result(last_result)
	);

	char_row_t directed [N_DIRECTED] = '{
		{8'h31, 1'b1, 1'b1, ST_NOT_BECH32, NET_MAIN},
		{8'hff, 1'b1, 1'b1, ST_NOT_BECH32, NET_MAIN},
		{8'h00, 1'b0, 1'b0, ST_OK, NET_MAIN},
		{8'h31, 1'b1, 1'b1, ST_NOT_BECH32, NET_MAIN},
		{"d", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"i", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"n", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"1", 1'b1, 1'b1, ST_SHORT, NET_MAIN},
		{"T", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"D", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"I", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"N", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"1", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"q", 1'b1, 1'b1, ST_SHORT, NET_TEST},
		{"r", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"d", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"i", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"n", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"1", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"b", 1'b1, 1'b1, ST_CHARSET, NET_REG},
		{"d", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"i", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"n", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"x", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"y", 1'b0, 1'b0, ST_OK, NET_MAIN},
		{"1", 1'b1, 1'b1, ST_NOT_BECH32, NET_MAIN}
	};

	addr_word_t  pending_words [$];
	logic [7:0]  text_q [$];
	logic [4:0]  sym_q [$];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          chars_sent = 0;
	logic        calm = 1'b0;

	logic [7:0]  hrp_buf [4];
	int          hrp_len;
	logic        hrp_ovf;
	logic        sep_seen;
	logic        bad_char;
	logic        extra_sep;
	logic [29:0] crc;
	logic [4:0]  delay_line [6];
	int          sym_count;
	logic [4:0]  version;
	logic [11:0] acc;
	int          acc_bits;
	logic [5:0]  nbytes;

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] set_case(input logic [7:0] c, input case_style_t style);
		if (c >= "a" && c <= "z" && (style == CASE_UPPER ||
			(style == CASE_MIXED && $urandom_range(0, 1) == 1)))
			return c - 8'd32;
		return c;
	endfunction

	function automatic logic [7:0] symbol_char(input int v);
		return ALPHABET[8 * (31 - v) +: 8];
	endfunction

	function automatic int symbol_value(input logic [7:0] c);
		for (int i = 0; i < 32; i++)
			if (symbol_char(i) == c)
				return i;
		return -1;
	endfunction

	function automatic logic [29:0] bch_step(input logic [29:0] r, input logic [4:0] v);
		logic [4:0][29:0] gens;
		logic [29:0]      n;
		gens = {GEN4, GEN3, GEN2, GEN1, GEN0};
		n = {r[24:0], v};
		for (int i = 0; i < 5; i++)
			if (r[25 + i])
				n = n ^ gens[i];
		return n;
	endfunction

	function automatic logic prefix_is(input string s);
		if (hrp_len != s.len())
			return 1'b0;
		for (int i = 0; i < s.len(); i++)
			if (hrp_buf[i] != s[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [1:0] net_of();
		if (hrp_ovf)
			return NET_NONE;
		if (prefix_is("din"))
			return NET_MAIN;
		if (prefix_is("tdin"))
			return NET_TEST;
		if (prefix_is("rdin"))
			return NET_REG;
		return NET_NONE;
	endfunction

	task automatic clear_decoder();
		for (int i = 0; i < 4; i++)
			hrp_buf[i] = 8'd0;
		for (int i = 0; i < 6; i++)
			delay_line[i] = 5'd0;
		hrp_len   = 0;
		hrp_ovf   = 1'b0;
		sep_seen  = 1'b0;
		bad_char  = 1'b0;
		extra_sep = 1'b0;
		crc       = CHK_INIT;
		sym_count = 0;
		version   = 5'd0;
		acc       = 12'd0;
		acc_bits  = 0;
		nbytes    = 6'd0;
	endtask

	task automatic post_word(input logic summ, input logic [7:0] b, input logic [3:0] st,
		input logic [1:0] atype, input logic [1:0] net);
		addr_word_t w;
		w.summary = summ;
		w.pbyte   = b;
		w.st      = st;
		w.atype   = atype;
		w.net     = (net == NET_NONE) ? NET_MAIN : net;
		w.plen    = nbytes;
		w.last    = summ;
		pending_words = {pending_words, w};
	endtask

	task automatic decode_char(input logic [7:0] raw, input logic eot, input logic typed,
		input logic [3:0] typed_st, input logic [1:0] typed_net);
		logic [7:0]  c;
		logic [4:0]  leaving;
		logic [29:0] seed;
		logic [1:0]  net;
		logic [3:0]  st;
		logic [1:0]  atype;
		logic        is32;
		logic        is32m;
		int          v;
		c = lower(raw);
		if (!sep_seen) begin
			if (c == CH_SEP) begin
				sep_seen = 1'b1;
				seed = CHK_INIT;
				if (net_of() != NET_NONE) begin
					for (int i = 0; i < hrp_len; i++)
						seed = bch_step(seed, {2'b00, hrp_buf[i][7:5]});
					seed = bch_step(seed, 5'd0);
					for (int i = 0; i < hrp_len; i++)
						seed = bch_step(seed, hrp_buf[i][4:0]);
				end
				crc = seed;
			end else if (hrp_len < 4) begin
				hrp_buf[hrp_len] = c;
				hrp_len++;
			end else begin
				hrp_ovf = 1'b1;
			end
		end else if (c == CH_SEP) begin
			extra_sep = 1'b1;
		end else begin
			v = symbol_value(c);
			if (v < 0) begin
				bad_char = 1'b1;
			end else begin
				leaving = delay_line[0];
				crc = bch_step(crc, v[4:0]);
				for (int i = 0; i < 5; i++)
					delay_line[i] = delay_line[i + 1];
				delay_line[5] = v[4:0];
				if (sym_count == 6) begin
					version = leaving;
				end else if (sym_count > 6) begin
					acc = {acc[6:0], leaving};
					acc_bits += 5;
					if (acc_bits >= 8) begin
						acc_bits -= 8;
						if (nbytes != 6'd63)
							nbytes++;
						post_word(1'b0, 8'(acc >> acc_bits), ST_OK, AT_KEYHASH, net_of());
					end
				end
				if (sym_count < MAX_DATA_CHARS)
					sym_count++;
			end
		end

		if (eot) begin
			net   = net_of();
			is32  = crc == CHK_INIT;
			is32m = crc == BECH32M_CONST;
			atype = AT_KEYHASH;
			st    = ST_OK;
			if (!sep_seen || extra_sep || net == NET_NONE)
				st = ST_NOT_BECH32;
			else if (bad_char)
				st = ST_CHARSET;
			else if (sym_count < 7)
				st = ST_SHORT;
			else if (!is32 && !is32m)
				st = ST_CHECKSUM;
			else if (version > 5'd16)
				st = ST_VERSION;
			else if (acc_bits >= 5 || (acc & ((12'd1 << acc_bits) - 12'd1)) != 12'd0)
				st = ST_PADDING;
			else if (version == 5'd0 && is32) begin
				if (nbytes == 6'd20)
					atype = AT_KEYHASH;
				else if (nbytes == 6'd32)
					atype = AT_SCRIPTHASH;
				else
					st = ST_V0LEN;
			end else if (version == 5'd1 && is32m) begin
				if (nbytes == 6'd32)
					atype = AT_TAPROOT;
				else
					st = ST_V1LEN;
			end else
				st = ST_VARIANT;
			if (st != ST_OK)
				atype = AT_KEYHASH;
			if (typed)
				post_word(1'b1, 8'd0, typed_st, AT_KEYHASH, typed_net);
			else
				post_word(1'b1, 8'd0, st, atype, net);
			clear_decoder();
		end
	endtask

	task automatic flag_failure(input string why);
		if (fail_count < 10)
			$display("%s", why);
		fail_count++;
	endtask

	task automatic send_char(input logic [7:0] c, input logic eot, input logic typed,
		input logic [3:0] typed_st, input logic [1:0] typed_net);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		char_in     <= c;
		end_of_text <= eot;
		do
			@(posedge clk);
		while (!in_ready);
		decode_char(c, eot, typed, typed_st, typed_net);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_words.size() != 0);
	endtask

	task automatic put_prefix(input string s, input case_style_t style);
		for (int i = 0; i < s.len(); i++)
			text_q = {text_q, set_case(s[i], style)};
	endtask

	task automatic build_address();
		int          hlen;
		int          nlen;
		int          ver;
		int          pos;
		int          nb;
		logic        use_m;
		logic [11:0] bits;
		logic [29:0] chk;
		logic [7:0]  lc;
		case_style_t style;
		mutation_t   mut;
		text_q.delete();
		sym_q.delete();

		if ($urandom_range(0, 9) == 0) begin
			nlen = $urandom_range(1, 16);
			for (int i = 0; i < nlen; i++)
				text_q = {text_q, 8'($urandom_range(0, 255))};
			return;
		end

		style = case_style_t'($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: put_prefix("din", style);
			4, 5:       put_prefix("tdin", style);
			6, 7:       put_prefix("rdin", style);
			default: begin
				nlen = $urandom_range(0, 6);
				for (int i = 0; i < nlen; i++)
					text_q = {text_q, set_case(8'("a" + $urandom_range(0, 25)), style)};
			end
		endcase
		hlen = text_q.size();

		ver = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 1);
		use_m = (ver != 0);
		if ($urandom_range(0, 7) == 0)
			use_m = !use_m;
		nlen = (ver == 0 && $urandom_range(0, 1) == 0) ? 20 : 32;
		if ($urandom_range(0, 14) == 0)
			nlen = $urandom_range(64, 90);
		else if ($urandom_range(0, 3) == 0)
			nlen = $urandom_range(0, 40);

		sym_q = {sym_q, 5'(ver)};
		bits = 12'd0;
		nb = 0;
		for (int i = 0; i < nlen; i++) begin
			bits = {bits[3:0], 8'($urandom_range(0, 255))};
			nb += 8;
			while (nb >= 5) begin
				nb -= 5;
				sym_q = {sym_q, 5'(bits >> nb)};
			end
		end
		if (nb > 0)
			sym_q = {sym_q, 5'(bits << (5 - nb))};
		if ($urandom_range(0, 9) == 0)
			sym_q = {sym_q, 5'($urandom_range(0, 31))};

		chk = CHK_INIT;
		for (int i = 0; i < hlen; i++) begin
			lc  = lower(text_q[i]);
			chk = bch_step(chk, {2'b00, lc[7:5]});
		end
		chk = bch_step(chk, 5'd0);
		for (int i = 0; i < hlen; i++) begin
			lc  = lower(text_q[i]);
			chk = bch_step(chk, lc[4:0]);
		end
		for (int i = 0; i < sym_q.size(); i++)
			chk = bch_step(chk, sym_q[i]);
		for (int i = 0; i < 6; i++)
			chk = bch_step(chk, 5'd0);
		chk = chk ^ (use_m ? BECH32M_CONST : CHK_INIT);
		for (int i = 0; i < 6; i++)
			sym_q = {sym_q, chk[5 * (5 - i) +: 5]};

		text_q = {text_q, CH_SEP};
		style = case_style_t'($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
		for (int i = 0; i < sym_q.size(); i++)
			text_q = {text_q, set_case(symbol_char(sym_q[i]), style)};

		if ($urandom_range(0, 3) == 0) begin
			mut = mutation_t'($urandom_range(0, 5));
			pos = $urandom_range(hlen + 1, text_q.size() - 1);
			case (mut)
				MUT_SWAP_SYMBOL: text_q[pos] = symbol_char($urandom_range(0, 31));
				MUT_INSERT_BYTE: text_q.insert(pos, 8'($urandom_range(0, 255)));
				MUT_INSERT_SEP:  text_q.insert(pos, CH_SEP);
				MUT_DROP_CHAR:   text_q.delete(pos);
				MUT_TRUNCATE: begin
					nlen = $urandom_range(1, text_q.size() - 1);
					while (text_q.size() > nlen)
						void'(text_q.pop_back());
				end
				default:
					text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
			endcase
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		addr_word_t got;
		addr_word_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {is_summary, prog_byte, status, addr_type, network_id, prog_length,
				last_result};
			if (pending_words.size() == 0) begin
				flag_failure($sformatf("unexpected word: sum=%0d byte=%h st=%0d ty=%0d net=%0d",
					got.summary, got.pbyte, got.st, got.atype, got.net));
			end else begin
				want = pending_words.pop_front();
				if (got !== want)
					flag_failure($sformatf({"mismatch: got sum=%0d byte=%h st=%0d ty=%0d net=%0d ",
						"len=%0d last=%0d, want sum=%0d byte=%h st=%0d ty=%0d net=%0d len=%0d last=%0d"},
						got.summary, got.pbyte, got.st, got.atype, got.net, got.plen, got.last,
						want.summary, want.pbyte, want.st, want.atype, want.net, want.plen,
						want.last));
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 12)) @(negedge clk);
			if (!calm) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		char_in     = 8'd0;
		end_of_text = 1'b0;
		clear_decoder();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_char(directed[i].ch, directed[i].eot, directed[i].typed, directed[i].st,
				directed[i].net);
		wait_drain();

		chars_sent = 0;
		while (chars_sent < RANDOM_CHARS) begin
			build_address();
			for (int i = 0; i < text_q.size(); i++)
				send_char(text_q[i], i == text_q.size() - 1, 1'b0, ST_OK, NET_MAIN);
			if (chars_sent >= CALM_AFTER)
				calm = 1'b1;
			else if ($urandom_range(0, 5) == 0)
				wait_drain();
		end

		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/b32ad_pkg.sv
sv/b32ad_engine.sv
sv/b32ad_outq.sv
sv/bech32_address_decoder_core.sv
sv/b32ad_checker.sv
tb/bech32_address_decoder_core_test.sv
